FILE: rtl/slcd_pkg.sv
package slcd_pkg;

   localparam int BYTE_W = 8;
   localparam int LEN_W  = 16;
   localparam int CRC_W  = 16;
   localparam int KIND_W = 2;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_SYNC_VALUE   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_LENGTH   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CRC_INIT     = 2'd2;

   localparam logic [BYTE_W-1:0] SYNC_RESET     = 8'hAA;
   localparam logic [LEN_W-1:0]  MAX_LEN_RESET  = 16'd1024;
   localparam logic [CRC_W-1:0]  CRC_INIT_RESET = 16'hFFFF;
   localparam logic [CRC_W-1:0]  CRC_POLY       = 16'h1021;

   localparam logic [KIND_W-1:0] KIND_PAYLOAD = 2'd0;
   localparam logic [KIND_W-1:0] KIND_CRC_OK  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CRC_BAD = 2'd2;

   localparam logic [1:0] PH_HUNT    = 2'd0;
   localparam logic [1:0] PH_HEADER  = 2'd1;
   localparam logic [1:0] PH_PAYLOAD = 2'd2;
   localparam logic [1:0] PH_CRC     = 2'd3;

   localparam logic [1:0] HDR_COMMAND  = 2'd0;
   localparam logic [1:0] HDR_SEQUENCE = 2'd1;
   localparam logic [1:0] HDR_LEN_LOW  = 2'd2;
   localparam logic [1:0] HDR_LEN_HIGH = 2'd3;

   // CRC-16-CCITT, MSB first, one byte
   function automatic logic [CRC_W-1:0] crc_add_byte(input logic [CRC_W-1:0] crc,
                                                      input logic [BYTE_W-1:0] b);
      logic [CRC_W-1:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if (c[CRC_W-1]) begin
            c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[CRC_W-2:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

FILE: rtl/sync_length_crc16_deframer.sv
// channel | direction | handshake          | payload
// req     | in        | req_valid/req_stall | req_rx_byte
// rsp     | out       | rsp_valid/rsp_stall | kind, command, sequence, byte, offset,
//         |           |                     | length, end_of_frame
// csr     | in        | csr_write_enable    | csr_index, csr_write_data
//
// One byte per cycle while not stalled: frame state and CRC update from the
// accepted byte; a result is loaded into the output register at the accepting
// edge and is valid from the next cycle on.
// Synchronous reset puts the block in sync hunt with control registers at defaults.
// A waiting result stalls the input only while rsp_stall holds it; if it is
// taken in the same cycle a new byte is accepted.
module sync_length_crc16_deframer (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [slcd_pkg::BYTE_W-1:0]       req_rx_byte,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [slcd_pkg::KIND_W-1:0]       rsp_result_kind,
   output logic [slcd_pkg::BYTE_W-1:0]       rsp_command_code,
   output logic [slcd_pkg::BYTE_W-1:0]       rsp_sequence_number,
   output logic [slcd_pkg::BYTE_W-1:0]       rsp_payload_byte,
   output logic [slcd_pkg::LEN_W-1:0]        rsp_payload_offset,
   output logic [slcd_pkg::LEN_W-1:0]        rsp_payload_length,
   output logic                              rsp_end_of_frame,
   input  logic                              csr_write_enable,
   input  logic [slcd_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [slcd_pkg::CSR_DATA_W-1:0]   csr_write_data
);

   logic [slcd_pkg::BYTE_W-1:0] sync_ff;
   logic [slcd_pkg::LEN_W-1:0]  max_len_ff;
   logic [slcd_pkg::CRC_W-1:0]  crc_init_ff;

   logic [1:0]                  phase_ff, phase_in;
   logic [1:0]                  hdr_cnt_ff, hdr_cnt_in;
   logic [slcd_pkg::BYTE_W-1:0] cmd_ff, cmd_in;
   logic [slcd_pkg::BYTE_W-1:0] seq_ff, seq_in;
   logic [slcd_pkg::LEN_W-1:0]  len_ff, len_in;
   logic [slcd_pkg::LEN_W-1:0]  rcvd_ff, rcvd_in;
   logic [slcd_pkg::CRC_W-1:0]  crc_ff, crc_in;
   logic [slcd_pkg::BYTE_W-1:0] crc_lo_ff, crc_lo_in;
   logic                        crc_cnt_ff, crc_cnt_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [slcd_pkg::KIND_W-1:0] kind_ff, kind_in;
   logic [slcd_pkg::BYTE_W-1:0] pbyte_ff, pbyte_in;
   logic [slcd_pkg::LEN_W-1:0]  poff_ff, poff_in;
   logic                        eof_ff, eof_in;
   logic [slcd_pkg::BYTE_W-1:0] rsp_cmd_ff, rsp_seq_ff;
   logic [slcd_pkg::LEN_W-1:0]  rsp_len_ff;

   logic                        accept;
   logic                        emit;
   logic [slcd_pkg::CRC_W-1:0]  crc_next;
   logic [slcd_pkg::LEN_W-1:0]  rcvd_inc;
   logic [slcd_pkg::LEN_W-1:0]  hdr_len;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;
   assign crc_next  = slcd_pkg::crc_add_byte(crc_ff, req_rx_byte);
   assign rcvd_inc  = rcvd_ff + 1'b1;
   assign hdr_len   = {req_rx_byte, len_ff[7:0]};

   always_comb begin
      phase_in   = phase_ff;
      hdr_cnt_in = hdr_cnt_ff;
      cmd_in     = cmd_ff;
      seq_in     = seq_ff;
      len_in     = len_ff;
      rcvd_in    = rcvd_ff;
      crc_in     = crc_ff;
      crc_lo_in  = crc_lo_ff;
      crc_cnt_in = crc_cnt_ff;
      emit       = 1'b0;
      kind_in    = slcd_pkg::KIND_PAYLOAD;
      pbyte_in   = '0;
      poff_in    = '0;
      eof_in     = 1'b0;
      case (phase_ff)
         slcd_pkg::PH_HUNT: begin
            if (req_rx_byte == sync_ff) begin
               hdr_cnt_in = '0;
               crc_in     = crc_init_ff;
               phase_in   = slcd_pkg::PH_HEADER;
            end
         end
         slcd_pkg::PH_HEADER: begin
            crc_in     = crc_next;
            hdr_cnt_in = hdr_cnt_ff + 1'b1;
            case (hdr_cnt_ff)
               slcd_pkg::HDR_COMMAND:  cmd_in = req_rx_byte;
               slcd_pkg::HDR_SEQUENCE: seq_in = req_rx_byte;
               slcd_pkg::HDR_LEN_LOW:  len_in = {8'h00, req_rx_byte};
               default: begin
                  len_in     = hdr_len;
                  rcvd_in    = '0;
                  crc_cnt_in = 1'b0;
                  crc_lo_in  = '0;
                  if (hdr_len > max_len_ff) begin
                     phase_in = slcd_pkg::PH_HUNT;
                  end else if (hdr_len == '0) begin
                     phase_in = slcd_pkg::PH_CRC;
                  end else begin
                     phase_in = slcd_pkg::PH_PAYLOAD;
                  end
               end
            endcase
         end
         slcd_pkg::PH_PAYLOAD: begin
            crc_in   = crc_next;
            emit     = 1'b1;
            pbyte_in = req_rx_byte;
            poff_in  = rcvd_ff;
            rcvd_in  = rcvd_inc;
            if (rcvd_inc == len_ff) begin
               crc_cnt_in = 1'b0;
               phase_in   = slcd_pkg::PH_CRC;
            end
         end
         default: begin
            if (!crc_cnt_ff) begin
               crc_lo_in  = req_rx_byte;
               crc_cnt_in = 1'b1;
            end else begin
               crc_cnt_in = 1'b0;
               phase_in   = slcd_pkg::PH_HUNT;
               emit       = 1'b1;
               eof_in     = 1'b1;
               kind_in    = ({req_rx_byte, crc_lo_ff} == crc_ff) ?
                            slcd_pkg::KIND_CRC_OK : slcd_pkg::KIND_CRC_BAD;
            end
         end
      endcase
   end

   assign rsp_valid_in = (accept & emit) | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_ff     <= slcd_pkg::SYNC_RESET;
         max_len_ff  <= slcd_pkg::MAX_LEN_RESET;
         crc_init_ff <= slcd_pkg::CRC_INIT_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            slcd_pkg::CSR_SYNC_VALUE: sync_ff     <= csr_write_data[slcd_pkg::BYTE_W-1:0];
            slcd_pkg::CSR_MAX_LENGTH: max_len_ff  <= csr_write_data;
            slcd_pkg::CSR_CRC_INIT:   crc_init_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= slcd_pkg::PH_HUNT;
         hdr_cnt_ff   <= '0;
         cmd_ff       <= '0;
         seq_ff       <= '0;
         len_ff       <= '0;
         rcvd_ff      <= '0;
         crc_ff       <= slcd_pkg::CRC_INIT_RESET;
         crc_lo_ff    <= '0;
         crc_cnt_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            phase_ff   <= phase_in;
            hdr_cnt_ff <= hdr_cnt_in;
            cmd_ff     <= cmd_in;
            seq_ff     <= seq_in;
            len_ff     <= len_in;
            rcvd_ff    <= rcvd_in;
            crc_ff     <= crc_in;
            crc_lo_ff  <= crc_lo_in;
            crc_cnt_ff <= crc_cnt_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && emit) begin
         kind_ff    <= kind_in;
         pbyte_ff   <= pbyte_in;
         poff_ff    <= poff_in;
         eof_ff     <= eof_in;
         rsp_cmd_ff <= cmd_ff;
         rsp_seq_ff <= seq_ff;
         rsp_len_ff <= len_ff;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_result_kind     = kind_ff;
   assign rsp_command_code    = rsp_cmd_ff;
   assign rsp_sequence_number = rsp_seq_ff;
   assign rsp_payload_byte    = pbyte_ff;
   assign rsp_payload_offset  = poff_ff;
   assign rsp_payload_length  = rsp_len_ff;
   assign rsp_end_of_frame    = eof_ff;

`ifndef ASSERT_OFF
   a_eof_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_end_of_frame |-> rsp_result_kind != slcd_pkg::KIND_PAYLOAD)
      else $error("end of frame carries payload kind");

   a_offset_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_end_of_frame |->
         rsp_result_kind == slcd_pkg::KIND_PAYLOAD && rsp_payload_offset < rsp_payload_length)
      else $error("payload offset beyond declared length");

   a_payload_count: assert property (@(posedge clock) disable iff (reset)
      phase_ff == slcd_pkg::PH_PAYLOAD |-> rcvd_ff < len_ff)
      else $error("payload count out of range");

   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled with empty output register");

   a_result_from_accept: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(accept) &&
         ($past(phase_ff) == slcd_pkg::PH_PAYLOAD || $past(phase_ff) == slcd_pkg::PH_CRC))
      else $error("result without payload or CRC transaction");
`endif

endmodule
